// ----- hw/rtl/ipap_pkg.sv -----
// ----------------------------------------------------------------------------
// ipap_pkg
// Shared types and constants for the partial IPv4 address parser.
// ----------------------------------------------------------------------------
package ipap_pkg;

  // Character codes
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Group limits
  localparam logic [9:0] OCTET_MAX  = 10'd255;
  localparam logic [2:0] DIGITS_MAX = 3'd3;
  localparam logic [2:0] GROUPS_MAX = 3'd4;

  // Configuration registers
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_LOCAL_ADDR   = 1'b0;
  localparam logic REG_DEFAULT_PORT = 1'b1;
  localparam logic [15:0] DEFAULT_PORT_RESET = 16'd26900;

  // Token queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_DOT,
    TK_COLON,
    TK_END,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  digit;
  } token_t;

endpackage

// ----- hw/rtl/ipap_front.sv -----
// ----------------------------------------------------------------------------
// ipap_front
// Classifies each incoming character into a token for the back end.
// ----------------------------------------------------------------------------
module ipap_front (
  input  logic                 in_valid,
  input  logic [7:0]           ch,
  input  logic                 q_full,
  output logic                 in_ready,
  output logic                 push,
  output ipap_pkg::token_t     push_token
);

  logic       is_digit;
  logic [7:0] digit_full;

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Character class
  assign is_digit   = (ch >= ipap_pkg::CH_ZERO) && (ch <= ipap_pkg::CH_NINE);
  assign digit_full = ch - ipap_pkg::CH_ZERO;

  always_comb begin
    push_token.digit = is_digit ? digit_full[3:0] : 4'd0;
    if (ch == ipap_pkg::CH_END) begin
      push_token.kind = ipap_pkg::TK_END;
    end else if (is_digit) begin
      push_token.kind = ipap_pkg::TK_DIGIT;
    end else if (ch == ipap_pkg::CH_DOT) begin
      push_token.kind = ipap_pkg::TK_DOT;
    end else if (ch == ipap_pkg::CH_COLON) begin
      push_token.kind = ipap_pkg::TK_COLON;
    end else begin
      push_token.kind = ipap_pkg::TK_OTHER;
    end
  end

endmodule

// ----- hw/rtl/ipap_queue.sv -----
// ----------------------------------------------------------------------------
// ipap_queue
// Short token queue decoupling the classifier from the parser.
// ----------------------------------------------------------------------------
module ipap_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ipap_pkg::token_t     push_token,
  input  logic                 pop,
  output logic                 q_full,
  output logic                 q_valid,
  output ipap_pkg::token_t     q_token
);

  localparam logic [ipap_pkg::QPTR_W:0] DEPTH_CNT = (ipap_pkg::QPTR_W + 1)'(ipap_pkg::QUEUE_DEPTH);

  ipap_pkg::token_t              mem [ipap_pkg::QUEUE_DEPTH];
  logic [ipap_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ipap_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ipap_pkg::QPTR_W:0]     count;

  assign q_full  = (count == DEPTH_CNT);
  assign q_valid = (count != '0);
  assign q_token = mem[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_token;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/ipap_back.sv -----
// ----------------------------------------------------------------------------
// ipap_back
// Runs the parse state on tokens and registers one result word per string.
// ----------------------------------------------------------------------------
module ipap_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  ipap_pkg::token_t     q_token,
  output logic                 pop,
  input  logic [31:0]          local_addr,
  input  logic [15:0]          default_port,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic [31:0]          address,
  output logic [15:0]          port
);

  typedef enum logic [1:0] {
    PH_OCTET,
    PH_PORT,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t      phase, phase_next;
  logic        at_start, at_start_next;
  logic [9:0]  group_value, group_value_next;
  logic [2:0]  digit_run, digit_run_next;
  logic [2:0]  group_count, group_count_next;
  logic [31:0] parsed_addr, parsed_addr_next;
  logic [15:0] port_accum, port_accum_next;
  logic        has_port, has_port_next;

  logic        is_end;
  logic        skip;
  logic        group_bad;
  logic [2:0]  group_closed_cnt;
  logic [31:0] group_closed_addr;
  logic [9:0]  group_digit;
  logic [15:0] port_digit;
  logic        res_status;
  logic [31:0] res_addr;
  logic [15:0] res_port;
  logic [31:0] mask;
  logic [2:0]  end_count;
  logic [31:0] end_parsed;

  // Pop unless an end token would overwrite a result still waiting
  assign is_end = (q_token.kind == ipap_pkg::TK_END);
  assign pop    = q_valid && !(is_end && out_valid && !out_ready);

  // Closing the current group
  assign group_bad         = (group_value > ipap_pkg::OCTET_MAX);
  assign group_closed_cnt  = (group_count < ipap_pkg::GROUPS_MAX) ? group_count + 3'd1
                                                                  : group_count;
  assign group_closed_addr = {parsed_addr[23:0], group_value[7:0]};

  // Decimal accumulate, times ten by shifts
  assign group_digit = (group_value << 3) + (group_value << 1) + {6'd0, q_token.digit};
  assign port_digit  = (port_accum << 3) + (port_accum << 1) + {12'd0, q_token.digit};

  assign skip = at_start && (q_token.kind == ipap_pkg::TK_DOT);

  // Next parse state for a non-end token
  always_comb begin
    phase_next       = phase;
    at_start_next    = 1'b0;
    group_value_next = group_value;
    digit_run_next   = digit_run;
    group_count_next = group_count;
    parsed_addr_next = parsed_addr;
    port_accum_next  = port_accum;
    has_port_next    = has_port;
    if (!skip) begin
      case (phase)
        PH_OCTET: begin
          case (q_token.kind)
            ipap_pkg::TK_DIGIT: begin
              if (digit_run >= ipap_pkg::DIGITS_MAX) begin
                phase_next = PH_ERROR;
              end else begin
                digit_run_next   = digit_run + 3'd1;
                group_value_next = group_digit;
              end
            end
            ipap_pkg::TK_DOT, ipap_pkg::TK_COLON: begin
              if (group_bad) begin
                phase_next = PH_ERROR;
              end else begin
                parsed_addr_next = group_closed_addr;
                group_count_next = group_closed_cnt;
                group_value_next = '0;
                digit_run_next   = '0;
                if (q_token.kind == ipap_pkg::TK_COLON) begin
                  has_port_next   = 1'b1;
                  port_accum_next = '0;
                  phase_next      = PH_PORT;
                end
              end
            end
            default: begin
              phase_next = PH_ERROR;
            end
          endcase
        end
        PH_PORT: begin
          if (q_token.kind == ipap_pkg::TK_DIGIT) begin
            port_accum_next = port_digit;
          end else begin
            phase_next = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result for an end token
  always_comb begin
    end_count  = (phase == PH_OCTET) ? group_closed_cnt : group_count;
    end_parsed = (phase == PH_OCTET) ? group_closed_addr : parsed_addr;
    case (end_count)
      3'd0:    mask = 32'hFFFF_FFFF;
      3'd1:    mask = 32'hFFFF_FF00;
      3'd2:    mask = 32'hFFFF_0000;
      3'd3:    mask = 32'hFF00_0000;
      default: mask = 32'h0000_0000;
    endcase
    res_status = (phase == PH_ERROR) || ((phase == PH_OCTET) && group_bad);
    res_addr   = res_status ? 32'd0 : ((local_addr & mask) | end_parsed);
    res_port   = res_status ? 16'd0 : (has_port ? port_accum : default_port);
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OCTET;
      at_start    <= 1'b1;
      group_value <= '0;
      digit_run   <= '0;
      group_count <= '0;
      parsed_addr <= '0;
      port_accum  <= '0;
      has_port    <= 1'b0;
    end else if (pop) begin
      if (is_end) begin
        phase       <= PH_OCTET;
        at_start    <= 1'b1;
        group_value <= '0;
        digit_run   <= '0;
        group_count <= '0;
        parsed_addr <= '0;
        port_accum  <= '0;
        has_port    <= 1'b0;
      end else begin
        phase       <= phase_next;
        at_start    <= at_start_next;
        group_value <= group_value_next;
        digit_run   <= digit_run_next;
        group_count <= group_count_next;
        parsed_addr <= parsed_addr_next;
        port_accum  <= port_accum_next;
        has_port    <= has_port_next;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_end) begin
      status  <= res_status;
      address <= res_addr;
      port    <= res_port;
    end
  end

endmodule

// ----- hw/rtl/partial_ipv4_address_parser_top.sv -----
// ----------------------------------------------------------------------------
// partial_ipv4_address_parser_top
// Parses dotted-decimal IPv4 text with optional port, one character a word.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid/in_ready    ch
//  output   out_valid/out_ready  status, address, port
//  config   APB psel/penable     paddr, pwdata, prdata
//
// One character per cycle while the queue has room; the classifier feeds a
// 4-word token queue and the parser retires one token a cycle; an output stall
// blocks it only at an end token, and the queue absorbs the characters behind
// it. With the queue empty, an end character is queued, then sets out_valid.
// Reset (rst, synchronous) clears the queue, parse state and registers.
// ----------------------------------------------------------------------------
module partial_ipv4_address_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipap_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [31:0]                   address,
  output logic [15:0]                   port
);

  logic [31:0]       local_addr;
  logic [15:0]       default_port;
  logic              wr_en;
  logic              q_full;
  logic              q_valid;
  logic              push;
  logic              pop;
  ipap_pkg::token_t  push_token;
  ipap_pkg::token_t  q_token;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr   <= '0;
      default_port <= ipap_pkg::DEFAULT_PORT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        ipap_pkg::REG_LOCAL_ADDR:   local_addr   <= pwdata;
        ipap_pkg::REG_DEFAULT_PORT: default_port <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ipap_pkg::REG_LOCAL_ADDR:   prdata = local_addr;
      ipap_pkg::REG_DEFAULT_PORT: prdata = {16'd0, default_port};
      default:                    prdata = '0;
    endcase
  end

  // Front: classify characters
  ipap_front u_front (
    .in_valid   (in_valid),
    .ch         (ch),
    .q_full     (q_full),
    .in_ready   (in_ready),
    .push       (push),
    .push_token (push_token)
  );

  // Token queue
  ipap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_token    (q_token)
  );

  // Back: parse and emit
  ipap_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_token      (q_token),
    .pop          (pop),
    .local_addr   (local_addr),
    .default_port (default_port),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .address      (address),
    .port         (port)
  );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the partial IPv4 address parser. Characters are
// fed one word at a time through a valid/ready driver. A local parser model
// predicts each end-of-text result, and a monitor compares the results
// field by field. Configuration goes through the APB port between phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CHARS   = 292;
  localparam int NUM_PHASES    = 6;

  typedef enum logic [1:0] {
    P_OCTET,
    P_PORT,
    P_DONE,
    P_ERROR
  } parse_phase_t;

  typedef struct packed {
    logic        status;
    logic [31:0] address;
    logic [15:0] port;
  } parse_result_t;

  // DUT connections
  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        psel     = 1'b0;
  logic                        penable  = 1'b0;
  logic                        pwrite   = 1'b0;
  logic [ipap_pkg::ADDR_W-1:0] paddr    = '0;
  logic [31:0]                 pwdata   = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  ch       = ipap_pkg::CH_END;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        status;
  logic [31:0]                 address;
  logic [15:0]                 port;

  // Stimulus and expected results
  logic [7:0]          char_q[$];
  parse_result_t       parse_results_q[$];
  int                  queued       = 0;
  int                  errors       = 0;
  int                  cycles       = 0;
  int                  send_gap     = 0;
  int                  take_gap     = 0;
  int                  send_gap_pct = 0;
  int                  take_gap_pct = 0;

  // Parser model: configuration and running state
  logic [31:0]         cfg_local = '0;
  logic [15:0]         cfg_port  = ipap_pkg::DEFAULT_PORT_RESET;
  parse_phase_t        mdl_phase;
  logic                mdl_first;
  logic [9:0]          mdl_grp_val;
  logic [2:0]          mdl_grp_digits;
  logic [2:0]          mdl_grp_cnt;
  logic [31:0]         mdl_octets;
  logic [15:0]         mdl_port_acc;
  logic                mdl_port_seen;

  partial_ipv4_address_parser_top u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .address   (address),
    .port      (port)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Model: back to the idle parse state
  function automatic void clear_parse();
    mdl_phase      = P_OCTET;
    mdl_first      = 1'b1;
    mdl_grp_val    = '0;
    mdl_grp_digits = '0;
    mdl_grp_cnt    = '0;
    mdl_octets     = '0;
    mdl_port_acc   = '0;
    mdl_port_seen  = 1'b0;
  endfunction

  // Model: shift the current group into the address; 0 if it is over 255
  function automatic logic close_group();
    if (mdl_grp_val > ipap_pkg::OCTET_MAX)
      return 1'b0;
    mdl_octets = (mdl_octets << 8) | {24'd0, mdl_grp_val[7:0]};
    if (mdl_grp_cnt < ipap_pkg::GROUPS_MAX)
      mdl_grp_cnt = mdl_grp_cnt + 3'd1;
    mdl_grp_val    = '0;
    mdl_grp_digits = '0;
    return 1'b1;
  endfunction

  // Model: take one character, queue a result on the end character
  function automatic void parse_char(logic [7:0] c);
    logic          is_digit;
    logic [3:0]    dval;
    logic [31:0]   mask;
    parse_result_t res;
    is_digit = (c >= ipap_pkg::CH_ZERO) && (c <= ipap_pkg::CH_NINE);
    dval     = is_digit ? 4'(c - ipap_pkg::CH_ZERO) : 4'd0;

    if (c == ipap_pkg::CH_END) begin
      if (mdl_phase == P_OCTET && !close_group())
        mdl_phase = P_ERROR;
      if (mdl_phase == P_ERROR) begin
        res = '{status: 1'b1, address: 32'd0, port: 16'd0};
      end else begin
        mask = (mdl_grp_cnt >= ipap_pkg::GROUPS_MAX) ? 32'd0
                                                     : (32'hFFFF_FFFF << (8 * mdl_grp_cnt));
        res.status  = 1'b0;
        res.address = (cfg_local & mask) | mdl_octets;
        res.port    = mdl_port_seen ? mdl_port_acc : cfg_port;
      end
      parse_results_q.push_back(res);
      clear_parse();
      return;
    end

    // a single leading dot stands in for the implied one
    if (mdl_first) begin
      mdl_first = 1'b0;
      if (c == ipap_pkg::CH_DOT)
        return;
    end

    case (mdl_phase)
      P_OCTET: begin
        if (is_digit) begin
          if (mdl_grp_digits >= ipap_pkg::DIGITS_MAX) begin
            mdl_phase = P_ERROR;
          end else begin
            mdl_grp_digits = mdl_grp_digits + 3'd1;
            mdl_grp_val    = mdl_grp_val * 10'd10 + {6'd0, dval};
          end
        end else if (c == ipap_pkg::CH_DOT) begin
          if (!close_group())
            mdl_phase = P_ERROR;
        end else if (c == ipap_pkg::CH_COLON) begin
          if (!close_group()) begin
            mdl_phase = P_ERROR;
          end else begin
            mdl_port_seen = 1'b1;
            mdl_port_acc  = '0;
            mdl_phase     = P_PORT;
          end
        end else begin
          mdl_phase = P_ERROR;
        end
      end
      P_PORT: begin
        if (is_digit)
          mdl_port_acc = mdl_port_acc * 16'd10 + {12'd0, dval};
        else
          mdl_phase = P_DONE;
      end
      default: ;
    endcase
  endfunction

  // Driver: one character word per handshake, random idle bursts
  always @(posedge clk) begin
    logic       nxt_valid;
    logic [7:0] nxt_ch;
    nxt_valid = in_valid;
    nxt_ch    = ch;
    if (rst) begin
      nxt_valid = 1'b0;
      send_gap  = 0;
      clear_parse();
    end else begin
      if (in_valid && in_ready) begin
        parse_char(ch);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (char_q.size() != 0) begin
          if ($urandom_range(0, 99) < send_gap_pct) begin
            send_gap = $urandom_range(1, 9) - 1;
          end else begin
            nxt_valid = 1'b1;
            nxt_ch    = char_q.pop_front();
          end
        end
      end
    end
    in_valid <= nxt_valid;
    ch       <= nxt_ch;
  end

  task automatic note_error(string msg);
    errors = errors + 1;
    if (errors <= 10)
      $display("tb: mismatch: %s", msg);
  endtask

  // Monitor: check results in order, stall the output at random
  always @(posedge clk) begin
    parse_result_t want;
    logic          nxt_ready;
    if (!rst && out_valid && out_ready) begin
      if (parse_results_q.size() == 0) begin
        note_error($sformatf("unexpected result status=%0d address=%h port=%0d",
                             status, address, port));
      end else begin
        want = parse_results_q.pop_front();
        if (status !== want.status)
          note_error($sformatf("status exp %0d got %0d", want.status, status));
        if (address !== want.address)
          note_error($sformatf("address exp %h got %h", want.address, address));
        if (port !== want.port)
          note_error($sformatf("port exp %0d got %0d", want.port, port));
      end
    end
    if (rst) begin
      nxt_ready = 1'b0;
      take_gap  = 0;
    end else if (take_gap > 0) begin
      nxt_ready = 1'b0;
      take_gap  = take_gap - 1;
    end else if ($urandom_range(0, 99) < take_gap_pct) begin
      nxt_ready = 1'b0;
      take_gap  = $urandom_range(1, 9) - 1;
    end else begin
      nxt_ready = 1'b1;
    end
    out_ready <= nxt_ready;
  end

  // Configuration write: setup then access
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ipap_pkg::REG_LOCAL_ADDR)
      cfg_local = val;
    else
      cfg_port = val[15:0];
  endtask

  // Wait for the sender to empty and every result to come back; checked
  // away from the rising edge so that the driver's updates have settled
  task automatic drain();
    @(negedge clk);
    while (char_q.size() != 0 || in_valid || parse_results_q.size() != 0)
      @(negedge clk);
  endtask

  function automatic void push_char(logic [7:0] c);
    char_q.push_back(c);
    queued = queued + 1;
  endfunction

  // Push a text followed by the end character
  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i]);
    push_char(ipap_pkg::CH_END);
  endfunction

  function automatic void push_digits(int nd, int v);
    int pw[3] = '{1, 10, 100};
    for (int k = nd - 1; k >= 0; k--)
      push_char(8'(ipap_pkg::CH_ZERO + (v / pw[k]) % 10));
  endfunction

  // One group of 0..3 digits, value within range
  function automatic void push_group();
    int nd;
    nd = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
    case (nd)
      3:       push_digits(3, $urandom_range(0, 255));
      2:       push_digits(2, $urandom_range(0, 99));
      1:       push_digits(1, $urandom_range(0, 9));
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] junk_char();
    return 8'($urandom_range(1, 255));
  endfunction

  // Random text: mostly well formed, some broken, some noise
  function automatic void push_random_address();
    int         kind;
    int         ngrp;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      if ($urandom_range(0, 4) == 0)
        push_char(ipap_pkg::CH_DOT);
      ngrp = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      for (int g = 0; g < ngrp; g++) begin
        if (g != 0)
          push_char(ipap_pkg::CH_DOT);
        push_group();
      end
      if ($urandom_range(0, 2) == 0) begin
        push_char(ipap_pkg::CH_COLON);
        repeat ($urandom_range(0, 6))
          push_char(8'(ipap_pkg::CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) push_char(junk_char());
      end
    end else if (kind < 92) begin
      repeat ($urandom_range(0, 2)) begin
        push_group();
        push_char(ipap_pkg::CH_DOT);
      end
      case ($urandom_range(0, 2))
        0: repeat (4) push_char(8'(ipap_pkg::CH_ZERO + $urandom_range(0, 9)));
        1: push_digits(3, $urandom_range(256, 999));
        default: begin
          do c = junk_char();
          while ((c >= ipap_pkg::CH_ZERO && c <= ipap_pkg::CH_NINE) ||
                 c == ipap_pkg::CH_DOT || c == ipap_pkg::CH_COLON);
          push_char(c);
        end
      endcase
      repeat ($urandom_range(0, 4)) push_char(junk_char());
    end else begin
      repeat ($urandom_range(1, 8)) push_char(junk_char());
    end
    push_char(ipap_pkg::CH_END);
  endfunction

  // Sequencing: reset, then phases of settings and text
  initial begin
    logic [31:0] la;
    logic [15:0] dp;
    int          start;
    int          n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      case (p)
        0:       begin la = 32'hC0A8_0A01; dp = 16'd8080;                     end
        1:       begin la = 32'hFFFF_FFFF; dp = 16'hFFFF;                     end
        2:       begin la = 32'h0000_0000; dp = 16'd0;                        end
        4:       begin la = 32'h7F00_0001; dp = ipap_pkg::DEFAULT_PORT_RESET; end
        default: begin la = $urandom();    dp = 16'($urandom());              end
      endcase
      cfg_write(ipap_pkg::REG_LOCAL_ADDR, la);
      cfg_write(ipap_pkg::REG_DEFAULT_PORT, {16'd0, dp});

      // phase 3 runs without idling; the last phase too
      send_gap_pct = (p == 3 || p == NUM_PHASES - 1) ? 0 : 15 + 10 * (p % 2);
      take_gap_pct = (p == 3 || p == NUM_PHASES - 1) ? 0 : 25 - 10 * (p % 2);

      if (p == 0) begin
        push_text("");
        push_text(".1..2:");
        push_text("1234");
        push_text("256");
        push_char(8'hFF);
        push_text("9");
        push_text("9....7:70000a");
      end

      start = queued;
      n     = 0;
      while (queued - start < PHASE_CHARS) begin
        push_random_address();
        n = n + 1;
        // hold the sender until everything is back
        if (p == 2 && n % 10 == 0)
          drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ipap_pkg.sv
hw/rtl/ipap_front.sv
hw/rtl/ipap_queue.sv
hw/rtl/ipap_back.sv
hw/rtl/partial_ipv4_address_parser_top.sv
bench/tb.sv
